[rtl/ptlru_pkg.sv]
// ----------------------------------------------------------------------------
// ptlru_pkg
// Shared types, widths and constants of the paged translation block with
// least-recently-used frame replacement.
// ----------------------------------------------------------------------------
package ptlru_pkg;

  // Default sizes of the page table and frame owner stores
  localparam int unsigned MAX_PROCESSES_DEF = 64;
  localparam int unsigned MAX_FRAMES_DEF    = 64;

  // Fixed geometry of one process's table and of an address
  localparam int unsigned PAGES_PER_PROCESS = 16;
  localparam int unsigned PAGE_W            = 4;
  localparam int unsigned OFFSET_W          = 6;
  localparam int unsigned STAMP_W           = 5;

  // Age clock limits
  localparam int unsigned CLOCK_LIMIT       = 31;
  localparam int unsigned STAMP_ABOVE_MAX   = 32;

  // Transfer field widths
  localparam int unsigned PROC_W            = 6;
  localparam int unsigned LADDR_W           = 10;
  localparam int unsigned FRAME_OUT_W       = 6;
  localparam int unsigned PADDR_OUT_W       = 12;

  // Configuration port
  localparam int unsigned APB_DW            = 32;
  localparam int unsigned APB_AW            = 3;
  localparam int unsigned CFG_W             = 7;

  typedef enum logic [0:0] {
    REG_PROCESS_COUNT = 1'b0,
    REG_FRAME_COUNT   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] process_count;
    logic [CFG_W-1:0] frame_count;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_EVICT,
    ST_WRITE,
    ST_WRAP,
    ST_FINAL,
    ST_DONE
  } state_e;

endpackage

[rtl/ptlru_if.sv]
// ----------------------------------------------------------------------------
// ptlru_if
// Valid/ready channels of the translation block: access requests and
// translation responses.
// ----------------------------------------------------------------------------
interface ptlru_req_if;
  import ptlru_pkg::*;

  logic               valid;
  logic               ready;
  logic [PROC_W-1:0]  process_id;
  logic [LADDR_W-1:0] logical_address;

  modport source (output valid, output process_id, output logical_address, input ready);
  modport sink   (input valid, input process_id, input logical_address, output ready);
endinterface

interface ptlru_rsp_if;
  import ptlru_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [FRAME_OUT_W-1:0] frame;
  logic [PADDR_OUT_W-1:0] physical_address;
  logic                   evicted;
  logic [PROC_W-1:0]      evicted_process;
  logic [PAGE_W-1:0]      evicted_page;

  modport source (output valid, output hit, output frame, output physical_address,
                  output evicted, output evicted_process, output evicted_page,
                  input ready);
  modport sink   (input valid, input hit, input frame, input physical_address,
                  input evicted, input evicted_process, input evicted_page,
                  output ready);
endinterface

[rtl/ptlru_regs.sv]
// ----------------------------------------------------------------------------
// ptlru_regs
// APB-style register file holding the process and frame counts.
// ----------------------------------------------------------------------------
module ptlru_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [ptlru_pkg::APB_AW-1:0]  paddr_i,
  input  logic [ptlru_pkg::APB_DW-1:0]  pwdata_i,
  output logic [ptlru_pkg::APB_DW-1:0]  prdata_o,
  output logic                          pready_o,
  output ptlru_pkg::cfg_t               cfg_o
);
  import ptlru_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  // Decode the word address
  assign idx      = reg_idx_e'(paddr_i[APB_AW-1:2]);
  assign wr_en    = psel_i & penable_i & pwrite_i & pready_o;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  // Update on a write access cycle
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_PROCESS_COUNT: cfg_d.process_count = pwdata_i[CFG_W-1:0];
        REG_FRAME_COUNT:   cfg_d.frame_count   = pwdata_i[CFG_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.process_count <= CFG_W'(1);
      cfg_q.frame_count   <= CFG_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Return the addressed register
  always_comb begin
    case (idx)
      REG_PROCESS_COUNT: prdata_o = APB_DW'(cfg_q.process_count);
      REG_FRAME_COUNT:   prdata_o = APB_DW'(cfg_q.frame_count);
      default:           prdata_o = '0;
    endcase
  end

endmodule

[rtl/paged_translation_lru_replace_core.sv]
// ----------------------------------------------------------------------------
// paged_translation_lru_replace_core
// Translates (process, logical address) accesses through per-process page
// tables, allocating frames and replacing the least recently used one.
//
// Usage: req_i carries process_id and logical_address, rsp_o returns hit,
// frame, physical_address and the evicted page, one response per request
// transfer, in order. Registers: process_count at 0x0, frame_count at 0x4.
// After reset all MAX_PROCESSES*16 page table entries (1024 by default) are
// swept to zero, one entry a cycle; no request is taken meanwhile.
// One request is worked on at a time. A miss scans the frame owner memory
// and page table memory in a three-stage pipeline, one frame a cycle, and
// stops at the first free frame; with none free, the owned frame with the
// oldest stamp is evicted. When the age clock wraps, a second pass restamps
// every owned frame below the configured frame count. A result waits in the
// output register while the next request is taken; if the receiver stalls,
// the following result holds until it is free.
// ----------------------------------------------------------------------------
module paged_translation_lru_replace_core #(
  parameter int unsigned MAX_PROCESSES = ptlru_pkg::MAX_PROCESSES_DEF,
  parameter int unsigned MAX_FRAMES    = ptlru_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptlru_pkg::APB_AW-1:0]  paddr,
  input  logic [ptlru_pkg::APB_DW-1:0]  pwdata,
  output logic [ptlru_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  ptlru_req_if.sink                     req_i,
  ptlru_rsp_if.source                   rsp_o
);
  import ptlru_pkg::*;

  localparam int unsigned PW       = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned FW       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned NPW      = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned NFW      = $clog2(MAX_FRAMES + 1);
  localparam int unsigned IW       = PW + PAGE_W;
  localparam int unsigned PT_DEPTH = MAX_PROCESSES * PAGES_PER_PROCESS;
  localparam int unsigned EW       = 1 + FW + STAMP_W;

  cfg_t cfg;

  ptlru_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // Memories and their ports
  logic [EW-1:0] pt_mem [PT_DEPTH];
  logic [IW-1:0] own_mem [MAX_FRAMES];

  logic          pt_we;
  logic [IW-1:0] pt_waddr, pt_raddr;
  logic [EW-1:0] pt_wdata, pt_rd_q;
  logic          own_we;
  logic [FW-1:0] own_waddr, own_raddr;
  logic [IW-1:0] own_wdata, own_rd_q;

  // Control and datapath registers
  state_e             state_q, state_d;
  logic [IW-1:0]      clr_q, clr_d;
  logic [NFW-1:0]     cnt_q, cnt_d;
  logic               s1_v_q, s1_v_d, s2_v_q, s2_v_d;
  logic [FW-1:0]      s1_idx_q, s1_idx_d, s2_idx_q, s2_idx_d;
  logic [IW-1:0]      s2_key_q, s2_key_d;
  logic [FW-1:0]      best_q, best_d;
  logic [IW-1:0]      best_key_q, best_key_d;
  logic [STAMP_W:0]   min_q, min_d;
  logic [MAX_FRAMES-1:0] owned_q;
  logic [STAMP_W-1:0] age_q, age_d;
  logic [IW-1:0]      key_q, key_d;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic               hit_q, hit_d, evict_q, evict_d;
  logic [FW-1:0]      frame_q, frame_d;
  logic               load_rsp;
  logic               rsp_valid_q, rsp_valid_d;

  logic [NPW-1:0]     nproc;
  logic [NFW-1:0]     nframes;
  logic [IW-1:0]      in_key;
  logic               in_use;

  // Clamp the configured counts to the supported range
  always_comb begin
    if (cfg.process_count == '0) begin
      nproc = NPW'(1);
    end else if (32'(cfg.process_count) > MAX_PROCESSES) begin
      nproc = NPW'(MAX_PROCESSES);
    end else begin
      nproc = NPW'(cfg.process_count);
    end
    if (cfg.frame_count == '0) begin
      nframes = NFW'(1);
    end else if (32'(cfg.frame_count) > MAX_FRAMES) begin
      nframes = NFW'(MAX_FRAMES);
    end else begin
      nframes = NFW'(cfg.frame_count);
    end
  end

  assign in_key = {PW'(req_i.process_id), req_i.logical_address[LADDR_W-1 -: PAGE_W]};
  assign in_use = 32'(req_i.process_id) < 32'(nproc);

  // Sequence reset sweep, lookup, replacement scan, write-back, clock wrap and hand-off
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cnt_d      = cnt_q;
    s1_v_d     = s1_v_q;
    s1_idx_d   = s1_idx_q;
    s2_v_d     = s2_v_q;
    s2_idx_d   = s2_idx_q;
    s2_key_d   = s2_key_q;
    best_d     = best_q;
    best_key_d = best_key_q;
    min_d      = min_q;
    age_d      = age_q;
    key_d      = key_q;
    offset_d   = offset_q;
    hit_d      = hit_q;
    evict_d    = evict_q;
    frame_d    = frame_q;
    load_rsp   = 1'b0;
    pt_we      = 1'b0;
    pt_waddr   = key_q;
    pt_wdata   = '0;
    pt_raddr   = key_q;
    own_we     = 1'b0;
    own_waddr  = frame_q;
    own_wdata  = key_q;
    own_raddr  = cnt_q[FW-1:0];
    req_i.ready = 1'b0;

    case (state_q)
      // Sweep the page table to invalid entries
      ST_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_q;
        if (clr_q == IW'(PT_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + IW'(1);
        end
      end

      // Take a request and read its page table entry
      ST_IDLE: begin
        req_i.ready = 1'b1;
        pt_raddr    = in_key;
        if (req_i.valid) begin
          key_d = in_key;
          if (in_use) begin
            offset_d = req_i.logical_address[OFFSET_W-1:0];
            state_d  = ST_LOOKUP;
          end else begin
            offset_d = '0;
            hit_d    = 1'b0;
            evict_d  = 1'b0;
            frame_d  = '0;
            state_d  = ST_DONE;
          end
        end
      end

      // Reuse a valid entry, else start the frame scan
      ST_LOOKUP: begin
        if (pt_rd_q[EW-1]) begin
          hit_d   = 1'b1;
          evict_d = 1'b0;
          frame_d = pt_rd_q[STAMP_W +: FW];
          state_d = ST_WRITE;
        end else begin
          hit_d   = 1'b0;
          cnt_d   = '0;
          min_d   = (STAMP_W+1)'(STAMP_ABOVE_MAX);
          state_d = ST_SCAN;
        end
      end

      // Owner read, entry read, stamp compare: one frame a cycle
      ST_SCAN: begin
        pt_raddr = own_rd_q;
        s2_v_d   = s1_v_q;
        s2_idx_d = s1_idx_q;
        s2_key_d = own_rd_q;
        if (s2_v_q && ({1'b0, pt_rd_q[STAMP_W-1:0]} < min_q)) begin
          min_d      = {1'b0, pt_rd_q[STAMP_W-1:0]};
          best_d     = s2_idx_q;
          best_key_d = s2_key_q;
        end
        if (cnt_q < nframes) begin
          if (!owned_q[cnt_q[FW-1:0]]) begin
            frame_d = cnt_q[FW-1:0];
            evict_d = 1'b0;
            s1_v_d  = 1'b0;
            s2_v_d  = 1'b0;
            state_d = ST_WRITE;
          end else begin
            s1_v_d   = 1'b1;
            s1_idx_d = cnt_q[FW-1:0];
            cnt_d    = cnt_q + NFW'(1);
          end
        end else begin
          s1_v_d = 1'b0;
          if (!s1_v_q && !s2_v_q) begin
            frame_d = best_q;
            evict_d = 1'b1;
            state_d = ST_EVICT;
          end
        end
      end

      // Invalidate the old owner's entry
      ST_EVICT: begin
        pt_we    = 1'b1;
        pt_waddr = best_key_q;
        pt_wdata = '0;
        state_d  = ST_WRITE;
      end

      // Write the entry, record the owner, advance the clock
      ST_WRITE: begin
        pt_we    = 1'b1;
        pt_waddr = key_q;
        pt_wdata = {1'b1, frame_q, age_q};
        if (!hit_q) begin
          own_we    = 1'b1;
          own_waddr = frame_q;
          own_wdata = key_q;
        end
        if (age_q < STAMP_W'(CLOCK_LIMIT - 1)) begin
          age_d   = age_q + STAMP_W'(1);
          state_d = ST_DONE;
        end else begin
          cnt_d   = '0;
          s1_v_d  = 1'b0;
          state_d = ST_WRAP;
        end
      end

      // Restamp the entry of every owned frame below the frame count to zero
      ST_WRAP: begin
        if (s1_v_q) begin
          pt_we    = 1'b1;
          pt_waddr = own_rd_q;
          pt_wdata = {1'b1, s1_idx_q, STAMP_W'(0)};
        end
        if (cnt_q < nframes) begin
          s1_v_d   = owned_q[cnt_q[FW-1:0]];
          s1_idx_d = cnt_q[FW-1:0];
          cnt_d    = cnt_q + NFW'(1);
        end else begin
          s1_v_d = 1'b0;
          if (!s1_v_q) begin
            state_d = ST_FINAL;
          end
        end
      end

      // Give the current entry the newest stamp
      ST_FINAL: begin
        pt_we    = 1'b1;
        pt_waddr = key_q;
        pt_wdata = {1'b1, frame_q, STAMP_W'(1)};
        age_d    = STAMP_W'(1);
        state_d  = ST_DONE;
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          load_rsp = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Page table memory
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rd_q <= pt_mem[pt_raddr];
  end

  // Frame owner memory
  always_ff @(posedge clk_i) begin
    if (own_we) begin
      own_mem[own_waddr] <= own_wdata;
    end
    own_rd_q <= own_mem[own_raddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      age_q       <= '0;
      owned_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      s1_v_q      <= s1_v_d;
      s2_v_q      <= s2_v_d;
      age_q       <= age_d;
      rsp_valid_q <= rsp_valid_d;
      if (own_we) begin
        owned_q[own_waddr] <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    s1_idx_q   <= s1_idx_d;
    s2_idx_q   <= s2_idx_d;
    s2_key_q   <= s2_key_d;
    best_q     <= best_d;
    best_key_q <= best_key_d;
    min_q      <= min_d;
    key_q      <= key_d;
    offset_q   <= offset_d;
    hit_q      <= hit_d;
    evict_q    <= evict_d;
    frame_q    <= frame_d;
  end

  // Output register
  assign rsp_valid_d = load_rsp | (rsp_valid_q & ~rsp_o.ready);
  assign rsp_o.valid = rsp_valid_q;

  always_ff @(posedge clk_i) begin
    if (load_rsp) begin
      rsp_o.hit              <= hit_q;
      rsp_o.frame            <= FRAME_OUT_W'(frame_q);
      rsp_o.physical_address <= {FRAME_OUT_W'(frame_q), offset_q};
      rsp_o.evicted          <= evict_q;
      rsp_o.evicted_process  <= evict_q ? PROC_W'(best_key_q[IW-1:PAGE_W]) : '0;
      rsp_o.evicted_page     <= evict_q ? best_key_q[PAGE_W-1:0] : '0;
    end
  end

endmodule

[verif/ptlru_translation_checker.sv]
// ----------------------------------------------------------------------------
// ptlru_translation_checker
// Watches the access, response and register channels of the translation
// block. It keeps its own page tables, frame owners and age clock, and
// predicts each response when an access transfer is taken. Every response
// transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ptlru_translation_checker
  import ptlru_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  ptlru_req_if              req_i,
  ptlru_rsp_if              rsp_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_ENTRIES = MAX_PROCESSES_DEF * PAGES_PER_PROCESS;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame;
    logic [PADDR_OUT_W-1:0] phys;
    logic                   evicted;
    logic [PROC_W-1:0]      ev_proc;
    logic [PAGE_W-1:0]      ev_page;
  } xlat_t;

  typedef struct packed {
    logic [PROC_W-1:0]  pid;
    logic [LADDR_W-1:0] laddr;
    xlat_t              res;
  } xlat_pending_t;

  // Shadow page tables, frame owners, age clock and registers
  logic                   pte_valid [N_ENTRIES];
  logic [FRAME_OUT_W-1:0] pte_frame [N_ENTRIES];
  logic [STAMP_W-1:0]     pte_stamp [N_ENTRIES];
  logic                   own_valid [MAX_FRAMES_DEF];
  logic [PROC_W-1:0]      own_proc  [MAX_FRAMES_DEF];
  logic [PAGE_W-1:0]      own_page  [MAX_FRAMES_DEF];
  logic [STAMP_W-1:0]     age_clk;
  cfg_t                   cfg_shadow;

  xlat_pending_t expected_xlat_q [$];
  int unsigned   fail_count;

  function automatic int unsigned effective_count(input logic [CFG_W-1:0] v,
                                                  input int unsigned ceiling);
    if (v == '0) return 1;
    if (v > ceiling) return ceiling;
    return v;
  endfunction

  function automatic int unsigned entry_at(input logic [PROC_W-1:0] p,
                                           input logic [PAGE_W-1:0] g);
    return p * PAGES_PER_PROCESS + g;
  endfunction

  // Translate one access and update the shadow state
  function automatic xlat_t translate_access(input logic [PROC_W-1:0] pid,
                                             input logic [LADDR_W-1:0] laddr);
    xlat_t             r;
    int unsigned       nproc, nfrm, idx, best, min_stamp, victim, e;
    logic [PAGE_W-1:0] pg;
    bit                found_free;
    r = '0;
    nproc = effective_count(cfg_shadow.process_count, MAX_PROCESSES_DEF);
    nfrm = effective_count(cfg_shadow.frame_count, MAX_FRAMES_DEF);
    if (pid >= nproc) return r;
    pg = laddr[LADDR_W-1:OFFSET_W];
    idx = entry_at(pid, pg);
    if (pte_valid[idx]) begin
      r.hit = 1'b1;
      r.frame = pte_frame[idx];
    end else begin
      // Take the first free frame, else the owned one with the oldest stamp
      found_free = 1'b0;
      best = 0;
      min_stamp = STAMP_ABOVE_MAX;
      for (int f = 0; f < nfrm && !found_free; f++) begin
        if (!own_valid[f]) begin
          r.frame = FRAME_OUT_W'(f);
          found_free = 1'b1;
        end else if (pte_stamp[entry_at(own_proc[f], own_page[f])] < min_stamp) begin
          min_stamp = pte_stamp[entry_at(own_proc[f], own_page[f])];
          best = f;
        end
      end
      if (!found_free) begin
        r.frame = FRAME_OUT_W'(best);
        r.evicted = 1'b1;
        r.ev_proc = own_proc[best];
        r.ev_page = own_page[best];
        victim = entry_at(own_proc[best], own_page[best]);
        pte_valid[victim] = 1'b0;
        pte_frame[victim] = '0;
        pte_stamp[victim] = '0;
      end
      own_valid[r.frame] = 1'b1;
      own_proc[r.frame] = pid;
      own_page[r.frame] = pg;
    end
    pte_valid[idx] = 1'b1;
    pte_frame[idx] = r.frame;
    pte_stamp[idx] = age_clk;
    if (int'(age_clk) + 1 < CLOCK_LIMIT) begin
      age_clk = age_clk + 1'b1;
    end else begin
      // Wrap: restamp every owned frame in range, current entry gets 1
      for (int f = 0; f < nfrm; f++) begin
        if (own_valid[f]) begin
          e = entry_at(own_proc[f], own_page[f]);
          pte_valid[e] = 1'b1;
          pte_frame[e] = FRAME_OUT_W'(f);
          pte_stamp[e] = '0;
        end
      end
      pte_valid[idx] = 1'b1;
      pte_frame[idx] = r.frame;
      pte_stamp[idx] = STAMP_W'(1);
      age_clk = STAMP_W'(1);
    end
    r.phys = {r.frame, laddr[OFFSET_W-1:0]};
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    xlat_pending_t want;
    xlat_t         got;
    if (!rst_ni) begin
      for (int i = 0; i < N_ENTRIES; i++) begin
        pte_valid[i] = 1'b0;
        pte_frame[i] = '0;
        pte_stamp[i] = '0;
      end
      for (int f = 0; f < MAX_FRAMES_DEF; f++) begin
        own_valid[f] = 1'b0;
        own_proc[f] = '0;
        own_page[f] = '0;
      end
      age_clk = '0;
      cfg_shadow.process_count = CFG_W'(1);
      cfg_shadow.frame_count = CFG_W'(1);
      expected_xlat_q.delete();
      fail_count = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // Check a response transfer against the oldest prediction
      if (rsp_i.valid && rsp_i.ready) begin
        got = '{rsp_i.hit, rsp_i.frame, rsp_i.physical_address, rsp_i.evicted,
                rsp_i.evicted_process, rsp_i.evicted_page};
        if (expected_xlat_q.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("[%0t] response with no access outstanding: %p", $realtime, got);
          fail_count++;
        end else begin
          want = expected_xlat_q.pop_front();
          if (got.hit !== want.res.hit || got.frame !== want.res.frame ||
              got.phys !== want.res.phys || got.evicted !== want.res.evicted ||
              got.ev_proc !== want.res.ev_proc || got.ev_page !== want.res.ev_page) begin
            if (fail_count < REPORT_MAX) begin
              $display("[%0t] mismatch for pid %0d laddr %03h", $realtime,
                       want.pid, want.laddr);
              $display("  expected hit %0b frame %0d pa %03h ev %0b ev_pid %0d ev_page %0d",
                       want.res.hit, want.res.frame, want.res.phys, want.res.evicted,
                       want.res.ev_proc, want.res.ev_page);
              $display("  actual   hit %0b frame %0d pa %03h ev %0b ev_pid %0d ev_page %0d",
                       got.hit, got.frame, got.phys, got.evicted, got.ev_proc,
                       got.ev_page);
            end
            fail_count++;
          end
        end
      end

      // Predict on an access transfer
      if (req_i.valid && req_i.ready) begin
        want.pid = req_i.process_id;
        want.laddr = req_i.logical_address;
        want.res = translate_access(req_i.process_id, req_i.logical_address);
        expected_xlat_q.push_back(want);
      end

      // Track register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[APB_AW-1:2]))
          REG_PROCESS_COUNT: cfg_shadow.process_count = pwdata_i[CFG_W-1:0];
          REG_FRAME_COUNT:   cfg_shadow.frame_count = pwdata_i[CFG_W-1:0];
          default: ;
        endcase
      end

      fail_count_o <= fail_count;
      pending_o <= expected_xlat_q.size();
    end
  end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives accesses and register writes into the paged translation block,
// with random idling on both channels and one long response stall. The
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
  import ptlru_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned SQUEEZE_CYCLES = 400;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt;
  logic        squeeze_req;
  logic        quiet;

  ptlru_req_if req_ch ();
  ptlru_rsp_if rsp_ch ();

  paged_translation_lru_replace_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch)
  );

  ptlru_translation_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort a run that stops making progress
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Offer one access, hold it until the transfer
  task automatic send_access(input logic [PROC_W-1:0] pid, input logic [LADDR_W-1:0] la);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.process_id <= pid;
    req_ch.logical_address <= la;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    logic [APB_DW-1:0] data;
    data = APB_DW'(val);
    if ($urandom_range(0, 1) == 1)
      data = data | ($urandom & {{(APB_DW-CFG_W){1'b1}}, {CFG_W{1'b0}}});
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, wait for all responses, then let the block finish its pass
  task automatic drain_and_settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random accesses: mostly in-range processes, pages from a pool of the given size
  task automatic random_accesses(input int unsigned n, input int unsigned procs,
                                 input int unsigned pages);
    int unsigned       served;
    logic [PROC_W-1:0] pid;
    logic [PAGE_W-1:0] pg;
    served = 0;
    while (served < n) begin
      if ($urandom_range(0, 9) == 0) pid = PROC_W'($urandom_range(0, 63));
      else pid = PROC_W'($urandom_range(0, procs - 1));
      pg = PAGE_W'($urandom_range(0, pages - 1));
      send_access(pid, {pg, OFFSET_W'($urandom_range(0, 63))});
      if (pid < procs) served++;
    end
  endtask

  // Response side: random stalls, one long hold-off
  initial begin : rsp_drain
    bit squeeze_done;
    squeeze_done = 1'b0;
    rsp_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
      end
      if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.process_id = '0;
    req_ch.logical_address = '0;
    squeeze_req = 1'b0;
    quiet = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: one process, one frame
    send_access(6'd0, 10'h000);
    send_access(6'd0, 10'h03F);
    send_access(6'd0, 10'h3EA);
    send_access(6'd63, 10'h3FF);
    send_access(6'd1, 10'h155);
    send_access(6'd0, 10'h000);
    drain_and_settle();

    // Full size: extremes of the fields, then random with the long stall
    write_reg(REG_PROCESS_COUNT, 7'd64);
    write_reg(REG_FRAME_COUNT, 7'd64);
    send_access(6'd63, 10'h3FF);
    send_access(6'd63, 10'h3C0);
    send_access(6'd42, 10'h2AA);
    send_access(6'd21, 10'h155);
    send_access(6'd32, 10'h200);
    send_access(6'd31, 10'h1FF);
    send_access(6'd0, 10'h000);
    send_access(6'd0, 10'h040);
    random_accesses(60, 64, 16);
    squeeze_req <= 1'b1;
    random_accesses(90, 64, 16);
    drain_and_settle();

    // Zero counts as one; higher frames keep serving hits
    write_reg(REG_PROCESS_COUNT, 7'd0);
    write_reg(REG_FRAME_COUNT, 7'd0);
    send_access(6'd0, 10'h000);
    send_access(6'd1, 10'h000);
    send_access(6'd0, 10'h3FF);
    random_accesses(40, 1, 16);
    drain_and_settle();

    // Values above the maximum clamp to it
    write_reg(REG_PROCESS_COUNT, 7'd127);
    write_reg(REG_FRAME_COUNT, 7'd127);
    random_accesses(120, 64, 4);
    drain_and_settle();

    // Few frames: heavy eviction
    write_reg(REG_PROCESS_COUNT, 7'd3);
    write_reg(REG_FRAME_COUNT, 7'd4);
    random_accesses(150, 3, 16);
    drain_and_settle();

    write_reg(REG_PROCESS_COUNT, 7'd64);
    write_reg(REG_FRAME_COUNT, 7'd8);
    random_accesses(120, 64, 2);
    drain_and_settle();

    write_reg(REG_PROCESS_COUNT, 7'd8);
    write_reg(REG_FRAME_COUNT, 7'd2);
    random_accesses(100, 8, 16);
    drain_and_settle();

    // Last stretch with no idling on either side
    write_reg(REG_PROCESS_COUNT, 7'd16);
    write_reg(REG_FRAME_COUNT, 7'd40);
    quiet <= 1'b1;
    random_accesses(120, 16, 8);
    drain_and_settle();

    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
